/* hdl/gpg_pkg.sv */
`default_nettype none
package gpg_pkg;

  localparam int GLYPH_SIZE   = 5;
  localparam int GLYPH_PIXELS = GLYPH_SIZE * GLYPH_SIZE;
  localparam int ADDR_W       = 18;
  localparam int WIDTH_W      = 11;
  localparam int COLOR_W      = 16;
  localparam int POS_W        = 18;
  localparam int MARGIN       = 40;
  localparam int ADVANCE      = 6;
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;

  localparam logic [WIDTH_W-1:0] FB_WIDTH_RESET = 11'd256;
  localparam logic               REG_FB_WIDTH   = 1'b0;

  typedef logic [GLYPH_PIXELS-1:0] pix_mask_t;

  // one character ready for drawing; mask bit k is pixel (k / 5, k % 5), lit and visible
  typedef struct packed {
    pix_mask_t            mask;
    logic [ADDR_W-1:0]    base;
    logic [WIDTH_W-1:0]   width;
    logic [COLOR_W-1:0]   color;
  } job_t;

  // rows top to bottom from the MSB end, leftmost pixel of a row at its MSB
  function automatic logic [GLYPH_PIXELS-1:0] glyph_bits(input logic [7:0] code);
    logic [GLYPH_PIXELS-1:0] g;
    case (code)
      8'h30: g = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h0E};
      8'h31: g = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h0E};
      8'h32: g = {5'h0E, 5'h11, 5'h06, 5'h08, 5'h1F};
      8'h33: g = {5'h1F, 5'h02, 5'h06, 5'h02, 5'h1F};
      8'h34: g = {5'h02, 5'h06, 5'h0A, 5'h1F, 5'h02};
      8'h35: g = {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h1E};
      8'h36: g = {5'h06, 5'h08, 5'h0E, 5'h11, 5'h0E};
      8'h37: g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08};
      8'h38: g = {5'h0E, 5'h11, 5'h0E, 5'h11, 5'h0E};
      8'h39: g = {5'h0E, 5'h11, 5'h0F, 5'h01, 5'h0E};
      8'h2B: g = {5'h00, 5'h04, 5'h0E, 5'h04, 5'h00};
      8'h2D: g = {5'h00, 5'h00, 5'h0E, 5'h00, 5'h00};
      8'h41, 8'h61: g = {5'h04, 5'h0A, 5'h11, 5'h1F, 5'h11};
      8'h55, 8'h75: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      8'h50: g = {5'h1E, 5'h11, 5'h1E, 5'h10, 5'h10};
      8'h7A: g = {5'h1F, 5'h02, 5'h04, 5'h08, 5'h1F};
      8'h69: g = {5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
      8'h6E: g = {5'h00, 5'h16, 5'h19, 5'h11, 5'h11};
      8'h6F: g = {5'h00, 5'h0E, 5'h11, 5'h11, 5'h0E};
      8'h65: g = {5'h0E, 5'h11, 5'h1E, 5'h10, 5'h0E};
      8'h6C: g = {5'h0C, 5'h04, 5'h04, 5'h04, 5'h0E};
      8'h74: g = {5'h08, 5'h1C, 5'h08, 5'h08, 5'h06};
      8'h6D: g = {5'h00, 5'h16, 5'h15, 5'h15, 5'h11};
      8'h70: g = {5'h00, 5'h16, 5'h19, 5'h1E, 5'h10};
      8'h63: g = {5'h00, 5'h0E, 5'h10, 5'h10, 5'h0E};
      default: g = '0;
    endcase
    return g;
  endfunction

  // 8 = 1 mod 7, so fold octal digits
  function automatic logic [2:0] mod7(input logic [7:0] v);
    logic [4:0] s1;
    logic [3:0] s2;
    s1 = 5'(v[2:0]) + 5'(v[5:3]) + 5'(v[7:6]);
    s2 = 4'(s1[2:0]) + 4'(s1[4:3]);
    return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
  endfunction

  function automatic logic [COLOR_W-1:0] palette(input logic [2:0] i);
    logic [COLOR_W-1:0] c;
    case (i)
      3'd0: c = 16'hFFFF;
      3'd1: c = 16'h9B5F;
      3'd2: c = 16'hAB8C;
      3'd3: c = 16'hA11F;
      3'd4: c = 16'hFE8A;
      3'd5: c = 16'hFD52;
      3'd6: c = 16'h925F;
      default: c = 16'hFFFF;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

/* hdl/gpg_front.sv */
`default_nettype none
module gpg_front #(
  parameter int FB_HEIGHT = 192,
  parameter int MAX_CHARS = 11
) (
  input  wire logic [7:0]                 char_code,
  input  wire logic [3:0]                 char_index,
  input  wire logic signed [15:0]         label_x,
  input  wire logic signed [15:0]         label_y,
  input  wire logic signed [11:0]         cam_x,
  input  wire logic signed [11:0]         cam_y,
  input  wire logic                       alive,
  input  wire logic [7:0]                 color_index,
  input  wire logic [gpg_pkg::WIDTH_W-1:0] width,
  output gpg_pkg::job_t                   job,
  output logic                            drawable
);
  import gpg_pkg::*;

  localparam int SY_W = $clog2(FB_HEIGHT + 1);

  logic signed [POS_W-1:0]   sx, sy, x0, w_s, dx;
  logic [POS_W-1:0]          idx6;
  logic [GLYPH_SIZE-1:0]     col_ok, row_ok;
  logic [GLYPH_PIXELS-1:0]   g;
  logic [SY_W-1:0]           sy_u;
  logic [SY_W+WIDTH_W-1:0]   prod;
  logic                      anchor_ok;

  always_comb begin
    sx = $signed({{2{label_x[15]}}, label_x}) - $signed({{2{cam_x[11]}}, cam_x, 4'b0000})
         + POS_W'(8);
    sy = $signed({{2{label_y[15]}}, label_y}) - $signed({{2{cam_y[11]}}, cam_y, 4'b0000});
    w_s  = $signed(POS_W'(width));
    idx6 = POS_W'({char_index, 2'b00}) + POS_W'({char_index, 1'b0});
    x0   = sx + $signed(idx6);

    anchor_ok = alive
             && (sx >= -$signed(POS_W'(MARGIN)))
             && (sx <= w_s + $signed(POS_W'(MARGIN)))
             && (sy >= $signed(POS_W'(0)))
             && (sy <= $signed(POS_W'(FB_HEIGHT)))
             && ({1'b0, char_index} < 5'(MAX_CHARS));

    for (int p = 0; p < GLYPH_SIZE; p++) begin
      dx = x0 + $signed(POS_W'(p));
      col_ok[p] = (dx >= $signed(POS_W'(0))) && (dx < w_s);
      row_ok[p] = (sy + $signed(POS_W'(p))) < $signed(POS_W'(FB_HEIGHT));
    end

    g = glyph_bits(char_code);
    for (int k = 0; k < GLYPH_PIXELS; k++) begin
      job.mask[k] = g[GLYPH_PIXELS-1-k] & col_ok[k % GLYPH_SIZE] & row_ok[k / GLYPH_SIZE];
    end

    sy_u      = sy[SY_W-1:0];
    prod      = sy_u * width;
    job.base  = ADDR_W'(prod) + ADDR_W'(x0);
    job.width = width;
    job.color = palette(mod7(color_index));
    drawable  = anchor_ok && (job.mask != '0);
  end

endmodule
`default_nettype wire

/* hdl/gpg_queue.sv */
`default_nettype none
module gpg_queue (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push_valid,
  output logic        push_ready,
  input  wire gpg_pkg::job_t push_job,
  output logic        pop_valid,
  input  wire logic   pop_ready,
  output gpg_pkg::job_t pop_job
);
  import gpg_pkg::*;

  job_t       slot [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       do_push, do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_job    = slot[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot[wr_ptr] <= push_job;
  end

endmodule
`default_nettype wire

/* hdl/gpg_back.sv */
`default_nettype none
module gpg_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         job_valid,
  output logic                              job_ready,
  input  wire gpg_pkg::job_t                job,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [gpg_pkg::ADDR_W-1:0]        pixel_address,
  output logic [gpg_pkg::COLOR_W-1:0]       pixel_color,
  output logic                              last
);
  import gpg_pkg::*;

  job_t              cur;
  logic              cur_valid;
  logic              advance, emit, finishing, found_r, found_c;
  logic [2:0]        py, px;
  logic [4:0]        rbits;
  pix_mask_t         remaining;
  logic [ADDR_W-1:0] rowoff, addr;

  always_comb begin
    py = '0;
    found_r = 1'b0;
    for (int r = 0; r < GLYPH_SIZE; r++) begin
      if (!found_r && (cur.mask[r*GLYPH_SIZE +: GLYPH_SIZE] != '0)) begin
        py = 3'(r);
        found_r = 1'b1;
      end
    end
    rbits = cur.mask[py*GLYPH_SIZE +: GLYPH_SIZE];
    px = '0;
    found_c = 1'b0;
    for (int c = 0; c < GLYPH_SIZE; c++) begin
      if (!found_c && rbits[c]) begin
        px = 3'(c);
        found_c = 1'b1;
      end
    end
    rowoff = (py[2] ? ADDR_W'({cur.width, 2'b00}) : '0)
           + (py[1] ? ADDR_W'({cur.width, 1'b0}) : '0)
           + (py[0] ? ADDR_W'(cur.width) : '0);
    addr      = cur.base + rowoff + ADDR_W'(px);
    remaining = cur.mask & (cur.mask - GLYPH_PIXELS'(1));
    finishing = (remaining == '0);
    advance   = !out_valid || out_ready;
    emit      = cur_valid && advance;
    job_ready = !cur_valid || (emit && finishing);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (job_ready && job_valid) begin
        cur_valid <= 1'b1;
      end else if (emit && finishing) begin
        cur_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_ready && job_valid) begin
      cur <= job;
    end else if (emit) begin
      cur.mask <= remaining;
    end
    if (emit) begin
      pixel_address <= addr;
      pixel_color   <= cur.color;
      last          <= finishing;
    end
  end

endmodule
`default_nettype wire

/* hdl/glyph_pixel_generator.sv */
`default_nettype none
// Channel | Handshake              | Payload
// in      | in_valid / in_ready    | char_code, char_index, label_x, label_y, cam_x, cam_y,
//         |                        | alive, color_index
// out     | out_valid / out_ready  | pixel_address, pixel_color, last
// apb     | psel, penable, pwrite  | paddr, pwdata, prdata, pready (fb_width at 0x0)
//
// One pixel write per cycle while out_ready is high; n visible lit pixels give n writes
// (at most 25) in the pixel walker, whose priority pick over the glyph mask sets the rate.
// From idle, an item is registered in a queue slot, then in the walker, then at the output.
// Items with nothing to draw produce no writes and are accepted whenever the queue has room.
// A two-entry job queue takes two more characters while the output is stalled.
// Reset clears the queue and output valid and sets fb_width to 256.
module glyph_pixel_generator #(
  parameter int FB_HEIGHT = 192,
  parameter int MAX_CHARS = 11,
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    char_code,
  input  wire logic [3:0]                    char_index,
  input  wire logic signed [15:0]            label_x,
  input  wire logic signed [15:0]            label_y,
  input  wire logic signed [11:0]            cam_x,
  input  wire logic signed [11:0]            cam_y,
  input  wire logic                          alive,
  input  wire logic [7:0]                    color_index,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [gpg_pkg::ADDR_W-1:0]         pixel_address,
  output logic [gpg_pkg::COLOR_W-1:0]        pixel_color,
  output logic                               last,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [gpg_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [gpg_pkg::PDATA_W-1:0]   pwdata,
  output logic [gpg_pkg::PDATA_W-1:0]        prdata,
  output logic                               pready
);
  import gpg_pkg::*;

  logic [WIDTH_W-1:0] fb_width;
  logic [WIDTH_W-1:0] width;
  logic               reg_hit;
  job_t               front_job, queue_job;
  logic               drawable, push_ready, pop_valid, pop_ready;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1] == REG_FB_WIDTH);
  assign prdata  = reg_hit ? PDATA_W'(fb_width) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fb_width <= FB_WIDTH_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      fb_width <= pwdata[WIDTH_W-1:0];
    end
  end

  assign width = (13'(fb_width) > 13'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : fb_width;

  gpg_front #(
    .FB_HEIGHT (FB_HEIGHT),
    .MAX_CHARS (MAX_CHARS)
  ) u_front (
    .char_code   (char_code),
    .char_index  (char_index),
    .label_x     (label_x),
    .label_y     (label_y),
    .cam_x       (cam_x),
    .cam_y       (cam_y),
    .alive       (alive),
    .color_index (color_index),
    .width       (width),
    .job         (front_job),
    .drawable    (drawable)
  );

  assign in_ready = push_ready;

  gpg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid && drawable),
    .push_ready (push_ready),
    .push_job   (front_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (queue_job)
  );

  gpg_back u_back (
    .clk           (clk),
    .rst           (rst),
    .job_valid     (pop_valid),
    .job_ready     (pop_ready),
    .job           (queue_job),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pixel_address (pixel_address),
    .pixel_color   (pixel_color),
    .last          (last)
  );

endmodule
`default_nettype wire

/* tb/sv/tb_glyph_pixel_generator.sv */
`timescale 1ns / 1ps

module tb_glyph_pixel_generator;
  import gpg_pkg::*;

  localparam int FB_ROWS       = 192;
  localparam int CHAR_LIMIT    = 11;
  localparam int WIDTH_CAP     = 1024;
  localparam int SETTLE_CYCLES = 64;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 50;

  localparam logic [PADDR_W-1:0] FB_WIDTH_ADDR = {REG_FB_WIDTH, 2'b00};

  typedef logic [0:GLYPH_SIZE-1][GLYPH_SIZE-1:0] glyph_rows_t;

  typedef struct packed {
    logic [7:0]  code;
    logic [3:0]  index;
    logic [15:0] lx;
    logic [15:0] ly;
    logic [11:0] cx;
    logic [11:0] cy;
    logic        alive;
    logic [7:0]  cidx;
    logic        no_writes;
  } char_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] color;
    logic               last;
  } pix_write_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [7:0]          char_code = '0;
  logic [3:0]          char_index = '0;
  logic signed [15:0]  label_x = '0;
  logic signed [15:0]  label_y = '0;
  logic signed [11:0]  cam_x = '0;
  logic signed [11:0]  cam_y = '0;
  logic                alive = 1'b0;
  logic [7:0]          color_index = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [ADDR_W-1:0]   pixel_address;
  logic [COLOR_W-1:0]  pixel_color;
  logic                last;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  pix_write_t   pending_writes [$];
  pix_write_t   exp_write;
  char_item_t   directed_rows [$];
  logic [10:0]  fb_width_model = FB_WIDTH_RESET;
  int           mismatches = 0;
  int           stall_left = 0;
  int           in_gap_pct = 0;
  int           out_stall_pct = 0;
  bit           calm = 1'b0;
  string        glyph_codes = "0123456789+-AaUuPzinoeltmpc ";

  glyph_pixel_generator #(
    .FB_HEIGHT(FB_ROWS),
    .MAX_CHARS(CHAR_LIMIT),
    .MAX_WIDTH(WIDTH_CAP)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .char_code(char_code),
    .char_index(char_index),
    .label_x(label_x),
    .label_y(label_y),
    .cam_x(cam_x),
    .cam_y(cam_y),
    .alive(alive),
    .color_index(color_index),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .pixel_address(pixel_address),
    .pixel_color(pixel_color),
    .last(last),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    // later ones are only counted
    if (mismatches <= 100) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic glyph_rows_t glyph_rows_of(input logic [7:0] code);
    glyph_rows_t g;
    case (code)
      "0": g = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h0E};
      "1": g = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h0E};
      "2": g = {5'h0E, 5'h11, 5'h06, 5'h08, 5'h1F};
      "3": g = {5'h1F, 5'h02, 5'h06, 5'h02, 5'h1F};
      "4": g = {5'h02, 5'h06, 5'h0A, 5'h1F, 5'h02};
      "5": g = {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h1E};
      "6": g = {5'h06, 5'h08, 5'h0E, 5'h11, 5'h0E};
      "7": g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08};
      "8": g = {5'h0E, 5'h11, 5'h0E, 5'h11, 5'h0E};
      "9": g = {5'h0E, 5'h11, 5'h0F, 5'h01, 5'h0E};
      "+": g = {5'h00, 5'h04, 5'h0E, 5'h04, 5'h00};
      "-": g = {5'h00, 5'h00, 5'h0E, 5'h00, 5'h00};
      "A", "a": g = {5'h04, 5'h0A, 5'h11, 5'h1F, 5'h11};
      "U", "u": g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      "P": g = {5'h1E, 5'h11, 5'h1E, 5'h10, 5'h10};
      "z": g = {5'h1F, 5'h02, 5'h04, 5'h08, 5'h1F};
      "i": g = {5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
      "n": g = {5'h00, 5'h16, 5'h19, 5'h11, 5'h11};
      "o": g = {5'h00, 5'h0E, 5'h11, 5'h11, 5'h0E};
      "e": g = {5'h0E, 5'h11, 5'h1E, 5'h10, 5'h0E};
      "l": g = {5'h0C, 5'h04, 5'h04, 5'h04, 5'h0E};
      "t": g = {5'h08, 5'h1C, 5'h08, 5'h08, 5'h06};
      "m": g = {5'h00, 5'h16, 5'h15, 5'h15, 5'h11};
      "p": g = {5'h00, 5'h16, 5'h19, 5'h1E, 5'h10};
      "c": g = {5'h00, 5'h0E, 5'h10, 5'h10, 5'h0E};
      default: g = '0;
    endcase
    return g;
  endfunction

  function automatic logic [COLOR_W-1:0] label_color(input logic [7:0] cidx);
    logic [COLOR_W-1:0] c;
    case (int'(cidx) % 7)
      0: c = 16'hFFFF;
      1: c = 16'h9B5F;
      2: c = 16'hAB8C;
      3: c = 16'hA11F;
      4: c = 16'hFE8A;
      5: c = 16'hFD52;
      default: c = 16'h925F;
    endcase
    return c;
  endfunction

  function automatic void predict_writes(input char_item_t it);
    glyph_rows_t rows;
    pix_write_t  pw;
    int w, lxs, lys, cxs, cys, sx, sy, idx, x0, dx, dy, lin, first;
    first = pending_writes.size();
    w = (fb_width_model > 11'd1024) ? WIDTH_CAP : int'(fb_width_model);
    lxs = int'($signed(it.lx));
    lys = int'($signed(it.ly));
    cxs = int'($signed(it.cx));
    cys = int'($signed(it.cy));
    idx = int'(it.index);
    sx = lxs - 16 * cxs + 8;
    sy = lys - 16 * cys;
    if (it.alive && sx >= -MARGIN && sx <= w + MARGIN && sy >= 0 && sy <= FB_ROWS &&
        idx < CHAR_LIMIT) begin
      rows = glyph_rows_of(it.code);
      x0 = sx + idx * ADVANCE;
      for (int py = 0; py < GLYPH_SIZE; py++) begin
        for (int px = 0; px < GLYPH_SIZE; px++) begin
          dx = x0 + px;
          dy = sy + py;
          if (rows[py][GLYPH_SIZE-1-px] && dx >= 0 && dx < w && dy >= 0 && dy < FB_ROWS) begin
            lin = dy * w + dx;
            pw.addr = lin[ADDR_W-1:0];
            pw.color = label_color(it.cidx);
            pw.last = 1'b0;
            pending_writes.push_back(pw);
          end
        end
      end
      if (pending_writes.size() > first) begin
        pw = pending_writes.pop_back();
        pw.last = 1'b1;
        pending_writes.push_back(pw);
      end
    end
  endfunction

  function automatic char_item_t mk(input logic [7:0] code, input int index, input int lx,
                                    input int ly, input int cx, input int cy, input bit live,
                                    input int cidx, input bit none);
    char_item_t it;
    it.code = code;
    it.index = index[3:0];
    it.lx = lx[15:0];
    it.ly = ly[15:0];
    it.cx = cx[11:0];
    it.cy = cy[11:0];
    it.alive = live;
    it.cidx = cidx[7:0];
    it.no_writes = none;
    return it;
  endfunction

  function automatic char_item_t random_item();
    char_item_t it;
    int w, tx, ty, cx, cy, lx, ly;
    w = (fb_width_model > 11'd1024) ? WIDTH_CAP : int'(fb_width_model);
    it.no_writes = 1'b0;
    it.cidx = 8'($urandom);
    if ($urandom_range(0, 9) < 2) begin
      // noise across the whole field ranges
      it.code = 8'($urandom);
      it.index = 4'($urandom);
      it.lx = 16'($urandom);
      it.ly = 16'($urandom);
      it.cx = 12'($urandom);
      it.cy = 12'($urandom);
      it.alive = 1'($urandom);
    end else begin
      it.code = glyph_codes[$urandom_range(0, glyph_codes.len() - 1)];
      it.index = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(CHAR_LIMIT, 15))
                                               : 4'($urandom_range(0, CHAR_LIMIT - 1));
      it.alive = ($urandom_range(0, 19) != 0);
      if ($urandom_range(0, 3) == 0) tx = $urandom_range(0, w + 100) - 50;
      else tx = $urandom_range(0, w + 10) - 5;
      if ($urandom_range(0, 4) == 0) ty = $urandom_range(0, FB_ROWS + 10) - 5;
      else ty = $urandom_range(0, FB_ROWS - GLYPH_SIZE);
      // camera kept where the label position still fits in 16 bits
      cx = $urandom_range(0, 4014) - 2044;
      cy = $urandom_range(0, 4014) - 2044;
      lx = tx - 8 + 16 * cx;
      ly = ty + 16 * cy;
      it.lx = lx[15:0];
      it.ly = ly[15:0];
      it.cx = cx[11:0];
      it.cy = cy[11:0];
    end
    return it;
  endfunction

  task automatic send_char(input char_item_t it);
    if (!calm && $urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    char_code <= it.code;
    char_index <= it.index;
    label_x <= it.lx;
    label_y <= it.ly;
    cam_x <= it.cx;
    cam_y <= it.cy;
    alive <= it.alive;
    color_index <= it.cidx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!it.no_writes) predict_writes(it);
  endtask

  task automatic write_fb_width(input logic [10:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= FB_WIDTH_ADDR;
    pwdata <= {21'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    fb_width_model = value;
    // straight into a read-back transfer
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== {21'd0, value})
      report_mismatch($sformatf("fb_width read %0d, wrote %0d", prdata, value));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain_writes();
    int waited;
    waited = 0;
    while (pending_writes.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_writes.size() != 0) begin
      report_mismatch($sformatf("%0d writes never arrived", pending_writes.size()));
      pending_writes.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 99) < out_stall_pct) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_writes.size() == 0) begin
        report_mismatch($sformatf("unexpected write addr %0d color %h last %b",
                                  pixel_address, pixel_color, last));
      end else begin
        exp_write = pending_writes.pop_front();
        if (pixel_address !== exp_write.addr)
          report_mismatch($sformatf("pixel_address %0d, expected %0d",
                                    pixel_address, exp_write.addr));
        if (pixel_color !== exp_write.color)
          report_mismatch($sformatf("pixel_color %h, expected %h",
                                    pixel_color, exp_write.color));
        if (last !== exp_write.last)
          report_mismatch($sformatf("last %b, expected %b at addr %0d",
                                    last, exp_write.last, exp_write.addr));
      end
    end
  end

  initial begin
    int gap_pcts [PHASES];
    int stall_pcts [PHASES];
    logic [10:0] phase_widths [PHASES];
    logic [10:0] width_now;
    gap_pcts = '{30, 0, 50, 10, 25, 0, 40, 0};
    stall_pcts = '{30, 50, 0, 20, 10, 0, 40, 0};
    phase_widths = '{11'd1024, 11'd1, 11'd2047, 11'd0, 11'd300, 11'd64, 11'd0, 11'd256};
    in_gap_pct = 20;
    out_stall_pct = 20;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // at the reset width of 256; screen anchor is sx = x + 8 with no camera
    directed_rows.push_back(mk("8", 0, 0, 10, 0, 0, 1, 0, 0));
    directed_rows.push_back(mk("A", 10, 100, 50, 0, 0, 1, 255, 0));
    directed_rows.push_back(mk("-", 3, -32768, 0, -2048, 0, 1, 7, 0));
    directed_rows.push_back(mk("P", 1, 32767, 32767, 2047, 2047, 1, 6, 0));
    directed_rows.push_back(mk("m", 0, -32768, -32768, -2048, -2048, 1, 13, 0));
    directed_rows.push_back(mk("1", 0, 0, 10, 0, 0, 0, 0, 1));
    directed_rows.push_back(mk("2", 0, -49, 10, 0, 0, 1, 1, 1));
    directed_rows.push_back(mk("3", 0, -48, 10, 0, 0, 1, 2, 0));
    directed_rows.push_back(mk("4", 0, 289, 10, 0, 0, 1, 3, 1));
    directed_rows.push_back(mk("5", 0, 288, 10, 0, 0, 1, 4, 0));
    directed_rows.push_back(mk("6", 0, 0, -1, 0, 0, 1, 5, 1));
    directed_rows.push_back(mk("7", 0, 0, 193, 0, 0, 1, 6, 1));
    directed_rows.push_back(mk("9", 0, 0, 192, 0, 0, 1, 7, 0));
    directed_rows.push_back(mk("e", 0, 0, 189, 0, 0, 1, 8, 0));
    directed_rows.push_back(mk("z", 0, -10, 20, 0, 0, 1, 9, 0));
    directed_rows.push_back(mk("o", 0, 245, 30, 0, 0, 1, 10, 0));
    directed_rows.push_back(mk("t", 11, 0, 10, 0, 0, 1, 11, 1));
    directed_rows.push_back(mk("l", 15, 0, 10, 0, 0, 1, 12, 1));
    directed_rows.push_back(mk(8'hFF, 0, 0, 10, 0, 0, 1, 0, 1));
    directed_rows.push_back(mk(" ", 0, 0, 10, 0, 0, 1, 0, 1));
    directed_rows.push_back(mk(8'h00, 0, 0, 10, 0, 0, 1, 0, 1));
    directed_rows.push_back(mk("u", 0, 0, 0, -2048, 0, 1, 0, 1));
    directed_rows.push_back(mk("U", 0, 0, 0, 2047, 0, 1, 0, 1));
    directed_rows.push_back(mk("c", 5, 0, 100, 0, 0, 1, 100, 0));
    directed_rows.push_back(mk("+", 2, 40, 60, 0, 0, 1, 200, 0));
    foreach (directed_rows[i]) send_char(directed_rows[i]);
    in_valid <= 1'b0;
    drain_writes();

    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1) calm = 1'b1;
      in_gap_pct = gap_pcts[p];
      out_stall_pct = stall_pcts[p];
      width_now = (p == 6) ? 11'($urandom_range(1, 2047)) : phase_widths[p];
      write_fb_width(width_now);
      for (int n = 0; n < PHASE_ITEMS; n++) send_char(random_item());
      in_valid <= 1'b0;
      drain_writes();
    end

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
